[sv/rbak_pkg.sv]
// Package for the rectangle boson autocorrelator kernel.
// Holds widths, the arctangent table, the pipeline metadata type and helpers.
// No dependencies; the CORDIC, the post stage, the top module and the checker use it.
package rbak_pkg;

  localparam int unsigned ATAN_ITERATIONS = 24;
  localparam int unsigned CORDIC_W = 44;
  localparam int unsigned ANGLE_W = 32;
  localparam int unsigned MAG_W = 34;
  localparam int unsigned SHIFT_W = 6;
  localparam int unsigned NORM_MSB = 40;
  localparam int unsigned POST_STAGES = 6;
  localparam int unsigned FRONT_STAGES = 2;
  localparam int unsigned TOTAL_STAGES = FRONT_STAGES + ATAN_ITERATIONS + POST_STAGES;

  localparam logic [31:0] TWO_OVER_PI_Q32 = 32'd2734261102;
  localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

  // floor(atan(2^-i) * 2^30)
  localparam logic [31:0] ATAN_TABLE [32] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
    32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
    32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
    32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255,
    32'd127, 32'd63, 32'd31, 32'd15, 32'd7, 32'd3, 32'd1, 32'd0, 32'd0
  };

  typedef struct packed {
    logic        static_f;
    logic [30:0] wd;
    logic [30:0] w;
    logic [30:0] h;
  } rbak_meta_t;

  // Left shift that brings the largest magnitude to bit NORM_MSB.
  function automatic logic [SHIFT_W-1:0] norm_shift(input logic [MAG_W-1:0] v);
    logic [SHIFT_W-1:0] k;
    k = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (v[i]) begin
        k = SHIFT_W'(NORM_MSB - i);
      end
    end
    return k;
  endfunction

endpackage

[sv/rbak_in_if.sv]
// Input channel of the kernel: one rectangle and one frequency per transfer.
// Depends on nothing.
interface rbak_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] center;
  logic [30:0] rect_width;
  logic [30:0] rect_height;
  logic [30:0] frequency;
  modport source (output valid, center, rect_width, rect_height, frequency, input ready);
  modport sink (input valid, center, rect_width, rect_height, frequency, output ready);
endinterface

[sv/rbak_out_if.sv]
// Output channel of the kernel: one saturated Q16.16 value per transfer.
// Depends on nothing.
interface rbak_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic        saturated;
  modport source (output valid, value, saturated, input ready);
  modport sink (input valid, value, saturated, output ready);
endinterface

[sv/rbak_cordic.sv]
// Pipelined vectoring CORDIC, one rotation per register stage.
// Depends on rbak_pkg for the widths, iteration count and angle table.
module rbak_cordic (
  input  logic                                     clk_i,
  input  logic                                     en_i,
  input  logic signed [rbak_pkg::CORDIC_W-1:0]     x_i,
  input  logic signed [rbak_pkg::CORDIC_W-1:0]     y_i,
  output logic signed [rbak_pkg::ANGLE_W-1:0]      z_o
);
  localparam int unsigned N = rbak_pkg::ATAN_ITERATIONS;

  logic signed [rbak_pkg::CORDIC_W-1:0] x_q [N];
  logic signed [rbak_pkg::CORDIC_W-1:0] y_q [N];
  logic signed [rbak_pkg::ANGLE_W-1:0]  z_q [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [rbak_pkg::CORDIC_W-1:0] x_in, y_in, xs, ys;
    logic signed [rbak_pkg::ANGLE_W-1:0]  z_in, ang;

    if (i == 0) begin : g_first
      assign x_in = x_i;
      assign y_in = y_i;
      assign z_in = '0;
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
    end

    assign xs  = x_in >>> i;
    assign ys  = y_in >>> i;
    assign ang = signed'(rbak_pkg::ATAN_TABLE[i]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!y_in[rbak_pkg::CORDIC_W-1]) begin
          x_q[i] <= x_in + ys;
          y_q[i] <= y_in - xs;
          z_q[i] <= z_in + ang;
        end else begin
          x_q[i] <= x_in - ys;
          y_q[i] <= y_in + xs;
          z_q[i] <= z_in - ang;
        end
      end
    end
  end

  assign z_o = z_q[N-1];

endmodule

[sv/rbak_post.sv]
// Post-processing pipeline: angle difference, inner term, height and 2/pi
// scaling, with rounding and saturation. Depends on rbak_pkg.
module rbak_post (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [rbak_pkg::ANGLE_W-1:0]   a1_i,
  input  logic signed [rbak_pkg::ANGLE_W-1:0]   a2_i,
  input  rbak_pkg::rbak_meta_t                  meta_i,
  output logic [31:0]                           value_o,
  output logic                                  saturated_o
);
  rbak_pkg::rbak_meta_t p1_meta_q, p2_meta_q;
  logic signed [32:0] p1_diff_q;
  logic signed [64:0] p2_prod_q;
  logic signed [33:0] p3_inner_q;
  logic [30:0]        p3_h_q;
  logic signed [63:0] p4_p_q;
  logic               p5_neg_q, p6_neg_q;
  logic [63:0]        p5_m_q, p6_lo_q, p6_hi_q;

  logic signed [31:0] w_s, h_s;
  logic signed [65:0] acc;
  logic [96:0]        tot;
  logic [48:0]        q;

  assign w_s = signed'({1'b0, p1_meta_q.w});
  assign h_s = signed'({1'b0, p3_h_q});
  assign acc = signed'({5'b0, p2_meta_q.wd, 30'b0}) + 66'(p2_prod_q)
             + signed'(66'(1) << 29);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_meta_q  <= meta_i;
      p1_diff_q  <= 33'(a1_i) - 33'(a2_i);
      p2_meta_q  <= p1_meta_q;
      p2_prod_q  <= w_s * p1_diff_q;
      p3_inner_q <= p2_meta_q.static_f ? signed'({3'b0, p2_meta_q.wd}) : acc[63:30];
      p3_h_q     <= p2_meta_q.h;
      p4_p_q     <= p3_inner_q * h_s;
      p5_neg_q   <= p4_p_q[63];
      p5_m_q     <= p4_p_q[63] ? 64'(-p4_p_q) : 64'(p4_p_q);
      p6_neg_q   <= p5_neg_q;
      p6_lo_q    <= p5_m_q[31:0] * rbak_pkg::TWO_OVER_PI_Q32;
      p6_hi_q    <= p5_m_q[63:32] * rbak_pkg::TWO_OVER_PI_Q32;
    end
  end

  assign tot = {1'b0, p6_hi_q, 32'b0} + {33'b0, p6_lo_q} + (97'(1) << 47);
  assign q   = tot[96:48];

  always_comb begin
    if (!p6_neg_q) begin
      saturated_o = q > 49'(rbak_pkg::POS_LIMIT);
      value_o     = saturated_o ? rbak_pkg::POS_LIMIT : q[31:0];
    end else begin
      saturated_o = q > 49'(rbak_pkg::NEG_LIMIT);
      value_o     = saturated_o ? rbak_pkg::NEG_LIMIT : 32'(-q[31:0]);
    end
  end

endmodule

[sv/rect_boson_autocorr_kernel.sv]
// Bosonic autocorrelator kernel for one rectangle at one frequency. Each input
// transfer gives exactly one output transfer, in order. The block is a
// pipeline of 32 register stages (two for edge forming and normalization, 24
// for the two parallel CORDIC arctangents, six for scaling) plus an output
// register; one item is taken every cycle while the output is drained. A
// two-entry output (output register plus skid register) decouples the sides:
// input ready drops only when the skid register is full, and then the whole
// pipeline holds.
module rect_boson_autocorr_kernel (
  input  logic        clk_i,
  input  logic        rst_ni,
  rbak_in_if.sink     in_i,
  rbak_out_if.source  out_o
);
  localparam int unsigned N  = rbak_pkg::ATAN_ITERATIONS;
  localparam int unsigned NS = rbak_pkg::TOTAL_STAGES;

  logic en;
  logic [NS-1:0] vld_q;

  // Stage 1: edges in Q16.17, doubled frequency and largest magnitudes.
  logic signed [34:0] s1_e1_q, s1_e2_q;
  logic [31:0]        s1_x_q;
  logic [rbak_pkg::MAG_W-1:0] s1_max1_q, s1_max2_q;
  rbak_pkg::rbak_meta_t s1_meta_q;

  logic signed [34:0] c2, wd_s, e1_d, e2_d;
  logic [rbak_pkg::MAG_W-1:0] mag1, mag2, xm;

  assign c2   = {{2{in_i.center[31]}}, in_i.center, 1'b0};
  assign wd_s = signed'({4'b0, in_i.rect_width});
  assign e1_d = c2 - wd_s;
  assign e2_d = c2 + wd_s;
  assign mag1 = e1_d[34] ? rbak_pkg::MAG_W'(-e1_d) : rbak_pkg::MAG_W'(e1_d);
  assign mag2 = e2_d[34] ? rbak_pkg::MAG_W'(-e2_d) : rbak_pkg::MAG_W'(e2_d);
  assign xm   = {2'b0, in_i.frequency, 1'b0};

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_e1_q   <= e1_d;
      s1_e2_q   <= e2_d;
      s1_x_q    <= {in_i.frequency, 1'b0};
      s1_max1_q <= (xm > mag1) ? xm : mag1;
      s1_max2_q <= (xm > mag2) ? xm : mag2;
      s1_meta_q <= '{static_f: (in_i.frequency == '0), wd: in_i.rect_width,
                     w: in_i.frequency, h: in_i.rect_height};
    end
  end

  // Stage 2: shift both vectors until the larger component reaches bit 40.
  logic signed [rbak_pkg::CORDIC_W-1:0] s2_x1_q, s2_y1_q, s2_x2_q, s2_y2_q;
  rbak_pkg::rbak_meta_t s2_meta_q;
  logic [rbak_pkg::SHIFT_W-1:0] k1, k2;
  logic signed [rbak_pkg::CORDIC_W-1:0] x_ext, y1_ext, y2_ext;

  assign k1     = rbak_pkg::norm_shift(s1_max1_q);
  assign k2     = rbak_pkg::norm_shift(s1_max2_q);
  assign x_ext  = signed'({12'b0, s1_x_q});
  assign y1_ext = rbak_pkg::CORDIC_W'(s1_e1_q);
  assign y2_ext = rbak_pkg::CORDIC_W'(s1_e2_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_x1_q   <= x_ext <<< k1;
      s2_y1_q   <= y1_ext <<< k1;
      s2_x2_q   <= x_ext <<< k2;
      s2_y2_q   <= y2_ext <<< k2;
      s2_meta_q <= s1_meta_q;
    end
  end

  // The two arctangents run side by side; metadata follows in a delay line.
  logic signed [rbak_pkg::ANGLE_W-1:0] a1, a2;
  rbak_pkg::rbak_meta_t meta_dly_q [N];

  rbak_cordic u_cordic_lo (
    .clk_i (clk_i), .en_i (en), .x_i (s2_x1_q), .y_i (s2_y1_q), .z_o (a1)
  );
  rbak_cordic u_cordic_hi (
    .clk_i (clk_i), .en_i (en), .x_i (s2_x2_q), .y_i (s2_y2_q), .z_o (a2)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      meta_dly_q[0] <= s2_meta_q;
      for (int i = 1; i < N; i++) begin
        meta_dly_q[i] <= meta_dly_q[i-1];
      end
    end
  end

  logic [31:0] post_value;
  logic        post_sat;

  rbak_post u_post (
    .clk_i       (clk_i),
    .en_i        (en),
    .a1_i        (a1),
    .a2_i        (a2),
    .meta_i      (meta_dly_q[N-1]),
    .value_o     (post_value),
    .saturated_o (post_sat)
  );

  // Valid bits travel alongside the data and hold with it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-2:0], in_i.valid};
    end
  end

  // Output register with a skid register behind it.
  logic        out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;
  logic [31:0] out_val_q, skid_val_q;
  logic        out_sat_q, skid_sat_q;
  logic        take, fire, load_out, load_skid, from_skid;

  assign en          = !skid_vld_q;
  assign in_i.ready  = en;
  assign take        = vld_q[NS-1] && en;
  assign fire        = out_vld_q && out_o.ready;

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    load_out   = 1'b0;
    load_skid  = 1'b0;
    from_skid  = 1'b0;
    if (fire) begin
      if (skid_vld_q) begin
        from_skid  = 1'b1;
        skid_vld_d = 1'b0;
      end else begin
        out_vld_d = 1'b0;
      end
    end
    if (take) begin
      if (!out_vld_q || fire) begin
        load_out  = 1'b1;
        out_vld_d = 1'b1;
      end else begin
        load_skid  = 1'b1;
        skid_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (from_skid) begin
      out_val_q <= skid_val_q;
      out_sat_q <= skid_sat_q;
    end else if (load_out) begin
      out_val_q <= post_value;
      out_sat_q <= post_sat;
    end
    if (load_skid) begin
      skid_val_q <= post_value;
      skid_sat_q <= post_sat;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.value     = out_val_q;
  assign out_o.saturated = out_sat_q;

  // The skid register only ever holds an item behind a waiting output.
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q) else $error("skid register full with empty output");

  // A finished item arriving at a stalled output must land in the skid register.
  a_skid_catch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && out_vld_q && !out_o.ready) |=> skid_vld_q)
    else $error("item lost at stalled output");

  // A held pipeline keeps its valid bits.
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q)) else $error("valid bits moved while stalled");

  // A clipped result sits at one of the two range limits.
  a_sat_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_sat_q) |->
      (out_val_q == rbak_pkg::POS_LIMIT || out_val_q == rbak_pkg::NEG_LIMIT))
    else $error("saturated result not at a limit");

endmodule

[dv/rect_boson_autocorr_kernel_chk.sv]
// Checker for the rectangle boson autocorrelator kernel testbench.
// Watches both channels, predicts each result and compares it in order.
// Depends on rbak_pkg, rbak_in_if and rbak_out_if.
`timescale 1ns / 100ps
module rect_boson_autocorr_kernel_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  rbak_in_if          in_i,
  rbak_out_if         out_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct {
    logic [31:0] value;
    logic        saturated;
  } kernel_res_t;

  kernel_res_t kernel_q[$];

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // CORDIC vectoring arctangent of y/x in Q2.30, x > 0.
  function automatic longint atan_q30(longint y, longint x);
    longint z, xs, ys, lim;
    z = 0;
    lim = longint'(1) << 40;
    while (((x > abs64(y)) ? x : abs64(y)) < lim) begin
      x = x * 2;
      y = y * 2;
    end
    for (int i = 0; i < rbak_pkg::ATAN_ITERATIONS && i < 32; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z += longint'(rbak_pkg::ATAN_TABLE[i]);
      end else begin
        x = x - ys;
        y = y + xs;
        z -= longint'(rbak_pkg::ATAN_TABLE[i]);
      end
    end
    return z;
  endfunction

  function automatic kernel_res_t kernel_value(logic [31:0] ctr, logic [30:0] wd_b,
                                               logic [30:0] h_b, logic [30:0] w_b);
    longint c, wd, h, w, inner, a1, a2, acc, p;
    logic [63:0] m, lo, hi, t, carry, q;
    logic neg;
    kernel_res_t r;
    c = longint'($signed(ctr));
    wd = longint'(wd_b);
    h = longint'(h_b);
    w = longint'(w_b);
    if (w == 0) begin
      inner = wd;
    end else begin
      a1 = atan_q30(2 * c - wd, 2 * w);
      a2 = atan_q30(2 * c + wd, 2 * w);
      acc = wd * 64'sd1073741824 + w * (a1 - a2);
      inner = floor_shr(acc + (longint'(1) << 29), 30);
    end
    p = inner * h;
    neg = p < 0;
    m = neg ? 64'(-p) : 64'(p);
    lo = {32'd0, m[31:0]} * {32'd0, rbak_pkg::TWO_OVER_PI_Q32};
    hi = {32'd0, m[63:32]} * {32'd0, rbak_pkg::TWO_OVER_PI_Q32};
    t = lo + (64'd1 << 47);
    carry = (t < lo) ? 64'd1 : 64'd0;
    q = (hi + (t >> 32) + (carry << 32)) >> 16;
    r.saturated = 1'b0;
    if (!neg) begin
      if (q > 64'h7FFF_FFFF) begin
        q = {32'd0, rbak_pkg::POS_LIMIT};
        r.saturated = 1'b1;
      end
      r.value = q[31:0];
    end else begin
      if (q > 64'h8000_0000) begin
        q = {32'd0, rbak_pkg::NEG_LIMIT};
        r.saturated = 1'b1;
      end
      r.value = -q[31:0];
    end
    return r;
  endfunction

  assign pending_o = kernel_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    kernel_res_t e;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        kernel_q.push_back(kernel_value(in_i.center, in_i.rect_width,
                                        in_i.rect_height, in_i.frequency));
      end
      if (out_i.valid && out_i.ready) begin
        if (kernel_q.size() == 0) begin
          $error("unexpected result value=%h", out_i.value);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = kernel_q.pop_front();
          if (e.value !== out_i.value || e.saturated !== out_i.saturated) begin
            if (e.value !== out_i.value)
              $error("value: expected %h actual %h", e.value, out_i.value);
            if (e.saturated !== out_i.saturated)
              $error("saturated: expected %b actual %b", e.saturated, out_i.saturated);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

[dv/rect_boson_autocorr_kernel_tb.sv]
// Top of the rectangle boson autocorrelator kernel testbench.
// Drives directed and random rectangles with bursty input and stalling output.
// Depends on both channel interfaces, the block and the checker.
`timescale 1ns / 100ps
module rect_boson_autocorr_kernel_tb;
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  bit stall_on = 1'b0;

  // Generous: the pipeline is 33 deep, and random gaps and stalls slow the
  // flow of items.
  localparam int unsigned CYCLE_LIMIT = 200000;

  rbak_in_if  in_ch ();
  rbak_out_if out_ch ();

  rect_boson_autocorr_kernel dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  rect_boson_autocorr_kernel_chk chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_i       (out_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #2 clk_i = ~clk_i;

  // The cycle counter stops a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("rect_boson_autocorr_kernel verification failed");
      $finish;
    end
  end

  // The receiver stalls in runs: a phase of free flow, then a phase in which
  // ready is random, so both long stalls and clean stretches occur.
  always @(negedge clk_i) begin
    if ($urandom_range(0, 63) == 0) stall_on <= ~stall_on;
    out_ch.ready <= stall_on ? ($urandom_range(0, 2) == 0) : 1'b1;
  end

  // Present one item and hold it until the transfer happens at a rising edge.
  task automatic send_rect(logic [31:0] ctr, logic [30:0] wd, logic [30:0] h,
                           logic [30:0] w);
    in_ch.valid <= 1'b1;
    in_ch.center <= ctr;
    in_ch.rect_width <= wd;
    in_ch.rect_height <= h;
    in_ch.frequency <= w;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic idle_gap(int unsigned n);
    in_ch.valid <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // Random field with a bias toward small magnitudes, which keep the result in
  // range, while still letting full-width values through.
  function automatic logic [30:0] rand_mag();
    case ($urandom_range(0, 3))
      0: return 31'($urandom);
      1: return 31'($urandom_range(0, 32'h0003_FFFF));
      2: return 31'($urandom_range(0, 32'h0000_FFFF));
      default: return 31'($urandom_range(0, 32'h0000_0FFF));
    endcase
  endfunction

  initial begin
    logic [31:0] ctr;
    int unsigned burst;
    in_ch.valid = 1'b0;
    in_ch.center = '0;
    in_ch.rect_width = '0;
    in_ch.rect_height = '0;
    in_ch.frequency = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: zero frequency, zero width, field extremes and overflow.
    send_rect(32'h0001_0000, 31'h0001_0000, 31'h0001_0000, 31'd0);
    send_rect(32'h0001_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd0);
    send_rect(32'h0000_0000, 31'd0, 31'h0001_0000, 31'h0001_0000);
    send_rect(32'h8000_0000, 31'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_rect(32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_rect(32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd1);
    send_rect(32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h0000_0001, 31'd1);
    send_rect(32'h0000_0000, 31'h0002_0000, 31'h0001_0000, 31'd1);
    send_rect(32'hFFFF_0000, 31'h0000_8000, 31'h0003_0000, 31'h0000_4000);
    send_rect(32'h0000_0000, 31'h0000_0001, 31'h0000_0001, 31'h7FFF_FFFF);
    send_rect(32'hFFFF_FFFF, 31'h5555_5555, 31'h2AAA_AAAA, 31'h5555_5555);
    send_rect(32'h0000_0000, 31'h2AAA_AAAA, 31'h5555_5555, 31'h2AAA_AAAA);
    send_rect(32'h0010_0000, 31'h0100_0000, 31'h0100_0000, 31'h0000_0100);

    // Hold off until everything in flight has been checked.
    idle_gap(1);
    while (pending != 0) @(negedge clk_i);

    // Random bursts with random gaps between them.
    for (int n = 0; n < 2000; ) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && n < 2000; b++, n++) begin
        ctr = ($urandom_range(0, 3) == 0) ? $urandom
                                          : 32'($signed(32'($urandom_range(0, 32'h7_FFFF)))
                                                - 32'sh4_0000);
        send_rect(ctr, rand_mag(), rand_mag(),
                  ($urandom_range(0, 7) == 0) ? 31'd0 : rand_mag());
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
    end
    idle_gap(1);

    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("rect_boson_autocorr_kernel verification clean");
    end else begin
      $display("rect_boson_autocorr_kernel verification failed");
    end
    $finish;
  end
endmodule

[rect_boson_autocorr_kernel.f]
sv/rbak_pkg.sv
sv/rbak_in_if.sv
sv/rbak_out_if.sv
sv/rbak_cordic.sv
sv/rbak_post.sv
sv/rect_boson_autocorr_kernel.sv
dv/rect_boson_autocorr_kernel_chk.sv
dv/rect_boson_autocorr_kernel_tb.sv
